[rtl/tcmpe_pkg.sv]
// shared types and constants for the cost matrix penalty engine
// no dependencies; imported by the top level
package tcmpe_pkg;

  // default sizing
  localparam int MAX_NODES_DEF = 16;
  localparam int COST_BITS_DEF = 16;

  // fixed field widths of the transaction ports
  localparam int OP_BITS    = 3;
  localparam int IDX_BITS   = 4;
  localparam int VALUE_BITS = 16;
  localparam int PEN_BITS   = 18;

  // configuration port
  localparam int PADDR_BITS    = 3;
  localparam int PDATA_BITS    = 32;
  localparam int REG_IDX_BITS  = PADDR_BITS - 2;
  localparam logic [REG_IDX_BITS-1:0] REG_INFINITY = '0;

  localparam logic [VALUE_BITS-1:0] INF_RESET = 16'd10000;
  localparam logic [PEN_BITS-1:0]   PEN_MAX   = '1;

  // operation codes
  typedef enum logic [OP_BITS-1:0] {
    OP_WRITE   = 3'd0,
    OP_READ    = 3'd1,
    OP_REMOVE  = 3'd2,
    OP_RESTORE = 3'd3,
    OP_PENALTY = 3'd4
  } op_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ_WAIT,
    ST_BLK_SCAN,
    ST_BLK_DRAIN,
    ST_COL_FIND,
    ST_BLK_READ,
    ST_BLK_WAIT,
    ST_PEN_SCAN,
    ST_PEN_DRAIN,
    ST_PEN_SUM,
    ST_DONE
  } state_t;

endpackage

[rtl/tcmpe_ram.sv]
// generic single-port ram with registered read
// no dependencies
module tcmpe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/tsp_cost_matrix_penalty_engine_unit.sv]
// Branch-and-bound cost matrix engine with penalty and block operations.
// Input transactions (in_valid/in_stall) carry operation, block_request, indices and a
// value; result transactions (out_valid/out_stall) carry one result for read, penalty
// and block, none for write, remove, restore or unused codes.
// The matrix sits in one single-port ram; one port and one compare unit are stepped
// by a small sequencer, one matrix entry per cycle, and in_stall stays high meanwhile.
// Steps from acceptance to the result loaded into the output register:
//   write, remove, restore: done on acceptance, the sequencer stays idle (no result)
//   read: one ram read, captured in ST_READ_WAIT
//   penalty: one column pass then one row pass through the ram, then the sum
//   block: full matrix scan through the ram, then a column search of one bit a cycle,
//     then, if a free row and column are found, a read and write of the chosen entry
// The ram read port sets the pace: one entry is read per cycle.
// A new transaction is taken as soon as the sequencer is idle, even while the last
// result waits in the output register; a result that finds the register still full
// and stalled is held in the sequencer until the receiver takes the old one.
// Reset (rst, synchronous) clears both removed masks, sets infinity_value to 10000
// and empties the output register; the matrix is undefined until written.
// infinity_value is register 0 of the apb port.
module tsp_cost_matrix_penalty_engine_unit
  import tcmpe_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int COST_BITS = COST_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_BITS-1:0]    operation,
  input  logic                  block_request,
  input  logic [IDX_BITS-1:0]   row_index,
  input  logic [IDX_BITS-1:0]   column_index,
  input  logic [VALUE_BITS-1:0] entry_value,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VALUE_BITS-1:0] result_value,
  output logic [IDX_BITS-1:0]   result_row,
  output logic [IDX_BITS-1:0]   result_column,
  output logic [PEN_BITS-1:0]   penalty,
  output logic                  found,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready
);

  localparam int NODE_BITS = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int DEPTH     = MAX_NODES * MAX_NODES;
  localparam int ADDR_BITS = $clog2(DEPTH);
  localparam int CMP_BITS  = (COST_BITS > VALUE_BITS + 1) ? COST_BITS : VALUE_BITS + 1;
  localparam int SUM_BITS  = CMP_BITS + 1;
  localparam logic [NODE_BITS-1:0] LAST    = NODE_BITS'(MAX_NODES - 1);
  localparam logic [ADDR_BITS-1:0] NODES_A = ADDR_BITS'(MAX_NODES);

  state_t state, state_next;

  logic                  accept;
  logic                  in_ok;
  logic                  out_free;

  logic [VALUE_BITS-1:0] infinity_value;
  logic                  cfg_write;

  logic [MAX_NODES-1:0]  row_removed;
  logic [MAX_NODES-1:0]  col_removed;
  logic [MAX_NODES-1:0]  row_inf;
  logic [MAX_NODES-1:0]  col_inf;

  logic [NODE_BITS-1:0]  req_row;
  logic [NODE_BITS-1:0]  req_col;
  logic [NODE_BITS-1:0]  cnt_a;
  logic [NODE_BITS-1:0]  cnt_b;
  logic                  phase;
  logic                  pend_valid;
  logic [NODE_BITS-1:0]  pend_a;
  logic [NODE_BITS-1:0]  pend_b;
  logic                  pend_phase;
  logic                  have_row;
  logic [NODE_BITS-1:0]  br;
  logic [NODE_BITS-1:0]  bc;
  logic [CMP_BITS-1:0]   acc;
  logic [CMP_BITS-1:0]   saved;

  logic [VALUE_BITS-1:0] res_value;
  logic [IDX_BITS-1:0]   res_row;
  logic [IDX_BITS-1:0]   res_col;
  logic [PEN_BITS-1:0]   res_pen;
  logic                  res_found;

  logic                  ram_we;
  logic [NODE_BITS-1:0]  ram_row;
  logic [NODE_BITS-1:0]  ram_col;
  logic [ADDR_BITS-1:0]  ram_addr;
  logic [COST_BITS-1:0]  ram_wdata;
  logic [COST_BITS-1:0]  ram_rdata;

  logic [CMP_BITS-1:0]   data_ext;
  logic [CMP_BITS-1:0]   inf_ext;
  logic [CMP_BITS-1:0]   inf2;
  logic                  blk_hit;
  logic                  row_pick;
  logic                  col_free;
  logic                  pen_elig;
  logic [CMP_BITS-1:0]   pen_min;
  logic [SUM_BITS-1:0]   pen_sum;
  logic [PEN_BITS-1:0]   pen_sat;

  // handshake
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_ok    = (32'(row_index) < 32'(MAX_NODES)) && (32'(column_index) < 32'(MAX_NODES));
  assign out_free = !out_valid || !out_stall;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[PADDR_BITS-1:2] == REG_INFINITY) ?
                     PDATA_BITS'(infinity_value) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      infinity_value <= INF_RESET;
    end else if (cfg_write && (paddr[PADDR_BITS-1:2] == REG_INFINITY)) begin
      infinity_value <= pwdata[VALUE_BITS-1:0];
    end
  end

  // shared compare unit on the ram read data
  assign data_ext = CMP_BITS'(ram_rdata);
  assign inf_ext  = CMP_BITS'(infinity_value);
  assign inf2     = CMP_BITS'({infinity_value, 1'b0});

  assign blk_hit  = pend_valid && !row_removed[pend_a] && !col_removed[pend_b] &&
                    (data_ext == inf_ext);
  assign row_pick = pend_valid && (pend_b == LAST) && !have_row && !row_removed[pend_a] &&
                    !row_inf[pend_a] && !blk_hit;
  assign col_free = !col_removed[cnt_b] && !col_inf[cnt_b];

  assign pen_elig = pend_phase ? ((pend_a != req_col) && !col_removed[pend_a]) :
                                 ((pend_a != req_row) && !row_removed[pend_a]);
  assign pen_min  = (pend_valid && pen_elig && (data_ext < acc)) ? data_ext : acc;

  // penalty sum with saturation
  assign pen_sum  = SUM_BITS'(saved) + SUM_BITS'(acc);
  assign pen_sat  = (pen_sum > SUM_BITS'(PEN_MAX)) ? PEN_MAX : PEN_BITS'(pen_sum);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (block_request) begin
            state_next = ST_BLK_SCAN;
          end else begin
            unique case (op_t'(operation))
              OP_READ:    state_next = in_ok ? ST_READ_WAIT : ST_DONE;
              OP_PENALTY: state_next = in_ok ? ST_PEN_SCAN : ST_DONE;
              default:    state_next = ST_IDLE;
            endcase
          end
        end
      end
      ST_READ_WAIT: state_next = ST_DONE;
      ST_BLK_SCAN: begin
        if ((cnt_a == LAST) && (cnt_b == LAST)) begin
          state_next = ST_BLK_DRAIN;
        end
      end
      ST_BLK_DRAIN: state_next = (have_row || row_pick) ? ST_COL_FIND : ST_DONE;
      ST_COL_FIND: begin
        if (col_free) begin
          state_next = ST_BLK_READ;
        end else if (cnt_b == LAST) begin
          state_next = ST_DONE;
        end
      end
      ST_BLK_READ:  state_next = ST_BLK_WAIT;
      ST_BLK_WAIT:  state_next = ST_DONE;
      ST_PEN_SCAN: begin
        if (phase && (cnt_a == LAST)) begin
          state_next = ST_PEN_DRAIN;
        end
      end
      ST_PEN_DRAIN: state_next = ST_PEN_SUM;
      ST_PEN_SUM:   state_next = ST_DONE;
      ST_DONE:      state_next = out_free ? ST_IDLE : ST_DONE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // ram port control
  always_comb begin
    ram_we    = 1'b0;
    ram_row   = req_row;
    ram_col   = req_col;
    ram_wdata = COST_BITS'(entry_value);
    unique case (state)
      ST_IDLE: begin
        ram_row = NODE_BITS'(row_index);
        ram_col = NODE_BITS'(column_index);
        ram_we  = accept && !block_request && in_ok && (op_t'(operation) == OP_WRITE);
      end
      ST_BLK_SCAN: begin
        ram_row = cnt_a;
        ram_col = cnt_b;
      end
      ST_BLK_READ: begin
        ram_row = br;
        ram_col = bc;
      end
      ST_BLK_WAIT: begin
        ram_row   = br;
        ram_col   = bc;
        ram_we    = 1'b1;
        ram_wdata = COST_BITS'(infinity_value);
      end
      ST_PEN_SCAN: begin
        ram_row = phase ? req_row : cnt_a;
        ram_col = phase ? cnt_a : req_col;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign ram_addr = ADDR_BITS'(ADDR_BITS'(ram_row) * NODES_A) + ADDR_BITS'(ram_col);

  tcmpe_ram #(
    .WIDTH (COST_BITS),
    .DEPTH (DEPTH)
  ) u_cost_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      row_removed <= '0;
      col_removed <= '0;
      pend_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= (state == ST_BLK_SCAN) || (state == ST_PEN_SCAN);
      if (accept && !block_request && in_ok) begin
        if (op_t'(operation) == OP_REMOVE) begin
          row_removed[NODE_BITS'(row_index)]    <= 1'b1;
          col_removed[NODE_BITS'(column_index)] <= 1'b1;
        end else if (op_t'(operation) == OP_RESTORE) begin
          row_removed[NODE_BITS'(row_index)]    <= 1'b0;
          col_removed[NODE_BITS'(column_index)] <= 1'b0;
        end
      end
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    pend_a     <= cnt_a;
    pend_b     <= cnt_b;
    pend_phase <= phase;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          req_row   <= NODE_BITS'(row_index);
          req_col   <= NODE_BITS'(column_index);
          cnt_a     <= '0;
          cnt_b     <= '0;
          phase     <= 1'b0;
          row_inf   <= '0;
          col_inf   <= '0;
          have_row  <= 1'b0;
          acc       <= inf2;
          res_value <= '0;
          res_row   <= '0;
          res_col   <= '0;
          res_pen   <= '0;
          res_found <= 1'b0;
        end
      end
      ST_READ_WAIT: res_value <= VALUE_BITS'(ram_rdata);
      ST_BLK_SCAN: begin
        if (cnt_b == LAST) begin
          cnt_b <= '0;
          cnt_a <= cnt_a + 1'b1;
        end else begin
          cnt_b <= cnt_b + 1'b1;
        end
      end
      ST_COL_FIND: begin
        if (col_free) begin
          bc <= cnt_b;
        end else begin
          cnt_b <= cnt_b + 1'b1;
        end
      end
      ST_BLK_WAIT: begin
        res_value <= VALUE_BITS'(ram_rdata);
        res_row   <= IDX_BITS'(br);
        res_col   <= IDX_BITS'(bc);
        res_found <= 1'b1;
      end
      ST_PEN_SCAN: begin
        if (cnt_a == LAST) begin
          cnt_a <= '0;
          phase <= 1'b1;
        end else begin
          cnt_a <= cnt_a + 1'b1;
        end
      end
      ST_PEN_SUM: res_pen <= pen_sat;
      default: begin
        res_found <= res_found;
      end
    endcase

    // infinity marks and first clean row during the block scan
    if ((state == ST_BLK_SCAN) || (state == ST_BLK_DRAIN)) begin
      if (blk_hit) begin
        row_inf[pend_a] <= 1'b1;
        col_inf[pend_b] <= 1'b1;
      end
      if (row_pick) begin
        br       <= pend_a;
        have_row <= 1'b1;
      end
    end

    // running minimum during the penalty scan
    if (((state == ST_PEN_SCAN) || (state == ST_PEN_DRAIN)) && pend_valid) begin
      if (!pend_phase && (pend_a == LAST)) begin
        saved <= pen_min;
        acc   <= inf2;
      end else begin
        acc <= pen_min;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      result_value  <= res_value;
      result_row    <= res_row;
      result_column <= res_col;
      penalty       <= res_pen;
      found         <= res_found;
    end
  end

  // checks
  a_colfind_has_row: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COL_FIND) |-> have_row)
    else $error("column search entered without a chosen row");

  a_blk_write_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BLK_WAIT) |-> ($past(state) == ST_BLK_READ))
    else $error("blocked entry written without its read");

  a_found_no_penalty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (penalty == '0))
    else $error("block result carries a penalty");

  a_pend_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> ((state == ST_BLK_SCAN) || (state == ST_BLK_DRAIN) ||
                    (state == ST_PEN_SCAN) || (state == ST_PEN_DRAIN)))
    else $error("ram data pending outside a scan");

endmodule

[sim/tb_top.sv]
// self-checking testbench for tsp_cost_matrix_penalty_engine_unit
// holds its own cost matrix model in a scoreboard class; needs rtl/tcmpe_pkg.sv and the top level
package tb_matrix_pkg;
  import tcmpe_pkg::*;

  localparam int NODES = MAX_NODES_DEF;
  localparam logic [OP_BITS-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_BITS-1:0] OP_SPARE_HI = 3'd7;
  localparam int unsigned SHOWN_MISMATCHES = 10;

  typedef struct packed {
    logic [OP_BITS-1:0]    operation;
    logic                  block_request;
    logic [IDX_BITS-1:0]   row;
    logic [IDX_BITS-1:0]   column;
    logic [VALUE_BITS-1:0] value;
  } matrix_cmd_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [IDX_BITS-1:0]   row;
    logic [IDX_BITS-1:0]   column;
    logic [PEN_BITS-1:0]   penalty;
    logic                  found;
  } matrix_result_t;

  class cost_matrix_scoreboard;
    bit [VALUE_BITS-1:0] cost [NODES*NODES];
    bit [NODES-1:0]      row_gone;
    bit [NODES-1:0]      col_gone;
    bit [VALUE_BITS-1:0] infinity;
    matrix_result_t      matrix_answers [$];
    int unsigned         mismatches;

    function new();
      foreach (cost[i]) cost[i] = '0;
      row_gone   = '0;
      col_gone   = '0;
      infinity   = INF_RESET;
      mismatches = 0;
    endfunction

    function void set_infinity(logic [PDATA_BITS-1:0] data);
      infinity = data[VALUE_BITS-1:0];
    endfunction

    function void note_mismatch(string what, longint unsigned want, longint unsigned got);
      mismatches++;
      if (mismatches <= SHOWN_MISMATCHES)
        $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endfunction

    // append one awaited result at the tail of the queue
    function void queue_answer(matrix_result_t answer);
      matrix_answers = {matrix_answers, answer};
    endfunction

    // column minimum over other active rows plus row minimum over other active columns
    function bit [PEN_BITS-1:0] penalty_at(int r, int c);
      int unsigned row_min;
      int unsigned col_min;
      int unsigned sum;
      row_min = 2 * int'(infinity);
      col_min = 2 * int'(infinity);
      for (int k = 0; k < NODES; k++) begin
        if (k != r && !row_gone[k] && cost[k*NODES+c] < row_min) row_min = cost[k*NODES+c];
        if (k != c && !col_gone[k] && cost[r*NODES+k] < col_min) col_min = cost[r*NODES+k];
      end
      sum = row_min + col_min;
      return (sum > int'(PEN_MAX)) ? PEN_MAX : PEN_BITS'(sum);
    endfunction

    // first active row and column carrying no infinity entry; that entry becomes infinity
    function matrix_result_t block_first_free();
      bit [NODES-1:0] row_mark;
      bit [NODES-1:0] col_mark;
      bit             have_row;
      bit             have_col;
      int             br;
      int             bc;
      matrix_result_t answer;
      row_mark = '0;
      col_mark = '0;
      have_row = 1'b0;
      have_col = 1'b0;
      br       = 0;
      bc       = 0;
      answer   = '0;
      for (int i = 0; i < NODES; i++)
        for (int j = 0; j < NODES; j++)
          if (!row_gone[i] && !col_gone[j] && cost[i*NODES+j] == infinity) begin
            row_mark[i] = 1'b1;
            col_mark[j] = 1'b1;
          end
      for (int i = 0; i < NODES; i++) begin
        if (!have_row && !row_gone[i] && !row_mark[i]) begin
          have_row = 1'b1;
          br       = i;
        end
        if (!have_col && !col_gone[i] && !col_mark[i]) begin
          have_col = 1'b1;
          bc       = i;
        end
      end
      if (have_row && have_col) begin
        answer.value          = cost[br*NODES+bc];
        answer.row            = IDX_BITS'(br);
        answer.column         = IDX_BITS'(bc);
        answer.found          = 1'b1;
        cost[br*NODES+bc]     = infinity;
      end
      return answer;
    endfunction

    // apply one accepted input transaction and queue the answer it causes
    function void note_input(matrix_cmd_t cmd);
      matrix_result_t answer;
      int             r;
      int             c;
      answer = '0;
      r      = int'(cmd.row);
      c      = int'(cmd.column);
      if (cmd.block_request) begin
        queue_answer(block_first_free());
      end else begin
        case (cmd.operation)
          OP_WRITE: cost[r*NODES+c] = cmd.value;
          OP_READ: begin
            answer.value = cost[r*NODES+c];
            queue_answer(answer);
          end
          OP_REMOVE: begin
            row_gone[r] = 1'b1;
            col_gone[c] = 1'b1;
          end
          OP_RESTORE: begin
            row_gone[r] = 1'b0;
            col_gone[c] = 1'b0;
          end
          OP_PENALTY: begin
            answer.penalty = penalty_at(r, c);
            queue_answer(answer);
          end
          default: ;
        endcase
      end
    endfunction

    function void check_result(matrix_result_t got);
      matrix_result_t want;
      if (matrix_answers.size() == 0) begin
        note_mismatch("unexpected result transaction", 0, got);
        return;
      end
      want = matrix_answers.pop_front();
      if (got.value   !== want.value)   note_mismatch("result_value", want.value, got.value);
      if (got.row     !== want.row)     note_mismatch("result_row", want.row, got.row);
      if (got.column  !== want.column)  note_mismatch("result_column", want.column, got.column);
      if (got.penalty !== want.penalty) note_mismatch("penalty", want.penalty, got.penalty);
      if (got.found   !== want.found)   note_mismatch("found", want.found, got.found);
    endfunction
  endclass
endpackage

module tb_top;
  import tcmpe_pkg::*;
  import tb_matrix_pkg::*;

  localparam int SETTLE_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES = 5;
  localparam logic [PADDR_BITS-1:0] INF_ADDR = {REG_INFINITY, 2'b00};

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  matrix_cmd_t           cmd_bus;
  logic                  out_valid;
  logic                  out_stall;
  logic [VALUE_BITS-1:0] result_value;
  logic [IDX_BITS-1:0]   result_row;
  logic [IDX_BITS-1:0]   result_column;
  logic [PEN_BITS-1:0]   penalty;
  logic                  found;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [PDATA_BITS-1:0] pwdata;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;

  bit                    idling_on = 1'b1;
  int unsigned           quiet_cycles = 0;
  cost_matrix_scoreboard sb = new();

  tsp_cost_matrix_penalty_engine_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (cmd_bus.operation),
    .block_request (cmd_bus.block_request),
    .row_index     (cmd_bus.row),
    .column_index  (cmd_bus.column),
    .entry_value   (cmd_bus.value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_value  (result_value),
    .result_row    (result_row),
    .result_column (result_column),
    .penalty       (penalty),
    .found         (found),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver stalls in random bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idling_on && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // monitors: check results before noting the input of the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        sb.check_result('{result_value, result_row, result_column, penalty, found});
      if (in_valid && !in_stall)
        sb.note_input(cmd_bus);
    end
  end

  // watchdog on cycles with no transaction on any port
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tsp_cost_matrix_penalty_engine_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic matrix_cmd_t make_cmd(logic [OP_BITS-1:0] op, logic blk,
                                           int r, int c, logic [VALUE_BITS-1:0] v);
    matrix_cmd_t cmd;
    cmd.operation     = op;
    cmd.block_request = blk;
    cmd.row           = IDX_BITS'(r);
    cmd.column        = IDX_BITS'(c);
    cmd.value         = v;
    return cmd;
  endfunction

  // costs lean on infinity and the extremes so that rows get marked
  function automatic logic [VALUE_BITS-1:0] pick_cost();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) return sb.infinity;
    if (pick < 35) return '0;
    if (pick < 45) return '1;
    if (pick < 60) return VALUE_BITS'(sb.infinity + $urandom_range(0, 2) - 1);
    return VALUE_BITS'($urandom);
  endfunction

  function automatic matrix_cmd_t random_command();
    matrix_cmd_t cmd;
    int unsigned pick;
    cmd  = make_cmd(OP_BITS'($urandom_range(0, 7)), 1'b0, $urandom_range(0, NODES - 1),
                    $urandom_range(0, NODES - 1), VALUE_BITS'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      cmd.operation = OP_WRITE;
      cmd.value     = pick_cost();
    end else if (pick < 50) cmd.operation = OP_READ;
    else if (pick < 65)     cmd.operation = OP_PENALTY;
    else if (pick < 78)     cmd.block_request = 1'b1;
    else if (pick < 86)     cmd.operation = OP_REMOVE;
    else if (pick < 96)     cmd.operation = OP_RESTORE;
    else                    cmd.operation = OP_BITS'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    return cmd;
  endfunction

  // one input transaction, with an optional gap in front
  task automatic send_command(input matrix_cmd_t cmd);
    @(negedge clk);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    cmd_bus  = cmd;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending and wait for every awaited result, optionally letting the engine settle
  task automatic wait_drained(input bit settle);
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.matrix_answers.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write of infinity_value followed by a read back
  task automatic write_infinity(input logic [PDATA_BITS-1:0] data);
    logic [PDATA_BITS-1:0] readback;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = INF_ADDR;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_infinity(data);
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (readback !== PDATA_BITS'(sb.infinity))
      sb.note_mismatch("infinity_value read back", sb.infinity, readback);
  endtask

  initial begin
    logic [PDATA_BITS-1:0] infinity_plan [PHASES];
    rst      = 1'b1;
    in_valid = 1'b0;
    cmd_bus  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // load the whole matrix; infinity on the diagonal marks every row
    for (int i = 0; i < NODES; i++)
      for (int j = 0; j < NODES; j++)
        send_command(make_cmd(OP_WRITE, 1'b0, i, j, (i == j) ? INF_RESET : pick_cost()));

    // directed: extremes, every operation, block not found, removed pair, spare codes
    send_command(make_cmd(OP_WRITE, 1'b0, 0, 1, '0));
    send_command(make_cmd(OP_READ, 1'b0, 0, 1, '1));
    send_command(make_cmd(OP_WRITE, 1'b0, 15, 14, '1));
    send_command(make_cmd(OP_READ, 1'b0, 15, 14, '0));
    send_command(make_cmd(OP_READ, 1'b0, 15, 15, '0));
    send_command(make_cmd(OP_PENALTY, 1'b0, 0, 1, '0));
    send_command(make_cmd(OP_PENALTY, 1'b0, 15, 15, '0));
    send_command(make_cmd(OP_WRITE, 1'b1, 7, 7, '1));
    send_command(make_cmd(OP_WRITE, 1'b0, 2, 2, 16'd5));
    send_command(make_cmd(OP_WRITE, 1'b1, 0, 0, '0));
    send_command(make_cmd(OP_READ, 1'b0, 2, 2, '0));
    send_command(make_cmd(OP_REMOVE, 1'b0, 3, 7, '0));
    send_command(make_cmd(OP_PENALTY, 1'b0, 3, 7, '0));
    send_command(make_cmd(OP_PENALTY, 1'b0, 0, 0, '0));
    send_command(make_cmd(OP_REMOVE, 1'b1, 3, 7, '0));
    send_command(make_cmd(OP_RESTORE, 1'b0, 3, 7, '0));
    send_command(make_cmd(OP_PENALTY, 1'b0, 15, 0, '0));
    for (int k = OP_SPARE_LO; k <= OP_SPARE_HI; k++)
      send_command(make_cmd(OP_BITS'(k), 1'b0, 4, 4, '1));
    send_command(make_cmd(OP_SPARE_HI, 1'b1, 15, 15, '1));
    send_command(make_cmd(OP_READ, 1'b0, 4, 4, '0));

    // random phases over several infinity settings; the last one runs without gaps
    infinity_plan[0] = 32'd1;
    infinity_plan[1] = 32'd65535;
    infinity_plan[2] = {16'($urandom), 16'($urandom_range(1, 65535))};
    infinity_plan[3] = PDATA_BITS'(INF_RESET);
    infinity_plan[4] = PDATA_BITS'($urandom_range(1, 65535));
    for (int p = 0; p < PHASES; p++) begin
      wait_drained(1'b1);
      write_infinity(infinity_plan[p]);
      idling_on = (p != PHASES - 1);
      for (int n = 0; n < ((p == PHASES - 1) ? 160 : 110); n++) begin
        send_command(random_command());
        if (p == 1 && n == 55) wait_drained(1'b0);
      end
    end

    // drain and report
    wait_drained(1'b1);
    if (sb.mismatches == 0 && sb.matrix_answers.size() == 0) begin
      $display("tsp_cost_matrix_penalty_engine_unit test passed");
    end else begin
      $display("tsp_cost_matrix_penalty_engine_unit test failed");
    end
    $finish;
  end
endmodule
